[rtl/core/caa_pkg.sv]
// caa_pkg: opcodes, status codes and pipeline control types of the checked integer alu
// no dependencies; used by caa_front and checked_integer_alu
package caa_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_MOD  = 4'd4,  OP_ABS = 4'd5,  OP_LT  = 4'd6,  OP_GE  = 4'd7,
    OP_AND  = 4'd8,  OP_OR  = 4'd9,  OP_XOR = 4'd10, OP_SHL = 4'd11,
    OP_LSR  = 4'd12, OP_ASR = 4'd13, OP_NOT = 4'd14, OP_BIT = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FAIL    = 3'd1,
    ST_INSUF   = 3'd2,
    ST_INTNEED = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  // where the final value of a request comes from
  typedef enum logic [2:0] {
    CLS_ERR  = 3'd0,
    CLS_PRED = 3'd1,
    CLS_VAL  = 3'd2,
    CLS_MUL  = 3'd3,
    CLS_DIV  = 3'd4,
    CLS_MOD  = 3'd5
  } cls_t;

  typedef struct packed {
    status_t status;
    cls_t    cls;
    logic    truth;
    logic    expect_given;
    logic    neg_q;
    logic    neg_r;
  } caa_ctl_t;

endpackage

[rtl/core/caa_front.sv]
// caa_front: first pipeline stage, operand checks, ops computed in this stage and divider setup
// depends on caa_pkg
module caa_front #(
  parameter int W = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3:0]            opcode,
  input  logic [63:0]           operand_a,
  input  logic [63:0]           operand_b,
  input  logic                  a_bound,
  input  logic                  b_bound,
  input  logic                  a_is_integer,
  input  logic                  b_is_integer,
  input  logic                  expect_given,
  input  logic [63:0]           expected_value,
  output logic                  vld_o,
  output caa_pkg::caa_ctl_t     ctl_o,
  output logic [W-1:0]          val_o,
  output logic [W-1:0]          exp_o,
  output logic [W-1:0]          a_o,
  output logic [W-1:0]          b_o,
  output logic [W-1:0]          abs_a_o,
  output logic [W-1:0]          abs_b_o
);
  import caa_pkg::*;

  localparam logic [6:0] WIDTH7 = 7'(W);

  logic              vld_r;
  caa_ctl_t          ctl_r, ctl_nxt;
  logic [W-1:0]      val_r, val_nxt;
  logic [W-1:0]      exp_r, a_r, b_r, abs_a_r, abs_b_r;
  logic signed [W-1:0] a, b;
  logic [5:0]        amt;
  logic              amt_big;
  logic [W-1:0]      a_shr;
  op_t               op;
  logic              unary;

  assign op      = op_t'(opcode);
  assign a       = operand_a[W-1:0];
  assign b       = operand_b[W-1:0];
  assign amt     = operand_b[5:0];
  assign amt_big = {1'b0, amt} >= WIDTH7;
  assign a_shr   = a >> amt;
  assign unary   = (op == OP_ABS) || (op == OP_NOT);

  always_comb begin
    ctl_nxt              = '0;
    ctl_nxt.status       = ST_OK;
    ctl_nxt.cls          = CLS_VAL;
    ctl_nxt.expect_given = expect_given;
    ctl_nxt.neg_q        = a[W-1] ^ b[W-1];
    ctl_nxt.neg_r        = a[W-1];
    val_nxt              = '0;
    unique case (op)
      OP_ADD: val_nxt = a + b;
      OP_SUB: val_nxt = a - b;
      OP_MUL: ctl_nxt.cls = CLS_MUL;
      OP_DIV: ctl_nxt.cls = CLS_DIV;
      OP_MOD: ctl_nxt.cls = CLS_MOD;
      OP_ABS: val_nxt = a[W-1] ? -a : a;
      OP_LT: begin
        ctl_nxt.cls   = CLS_PRED;
        ctl_nxt.truth = a < b;
      end
      OP_GE: begin
        ctl_nxt.cls   = CLS_PRED;
        ctl_nxt.truth = !(a < b);
      end
      OP_AND: val_nxt = a & b;
      OP_OR:  val_nxt = a | b;
      OP_XOR: val_nxt = a ^ b;
      OP_SHL: val_nxt = a << amt;
      OP_LSR: val_nxt = a >> amt;
      OP_ASR: val_nxt = a >>> amt;
      OP_NOT: val_nxt = ~a;
      OP_BIT: begin
        ctl_nxt.cls   = CLS_PRED;
        ctl_nxt.truth = amt_big ? a[W-1] : a_shr[0];
      end
      default: val_nxt = '0;
    endcase
    // tag checks override the op result, bound before integer before zero divisor
    priority if (!a_bound || (!unary && !b_bound)) begin
      ctl_nxt.cls    = CLS_ERR;
      ctl_nxt.status = ST_INSUF;
    end else if (!a_is_integer || (!unary && !b_is_integer)) begin
      ctl_nxt.cls    = CLS_ERR;
      ctl_nxt.status = ST_INTNEED;
    end else if ((op == OP_DIV || op == OP_MOD) && b == '0) begin
      ctl_nxt.cls    = CLS_ERR;
      ctl_nxt.status = ST_DIVZERO;
    end else begin
      ctl_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
    if (en) begin
      ctl_r   <= ctl_nxt;
      val_r   <= val_nxt;
      exp_r   <= expected_value[W-1:0];
      a_r     <= a;
      b_r     <= b;
      abs_a_r <= a[W-1] ? -a : a;
      abs_b_r <= b[W-1] ? -b : b;
    end
  end

  assign vld_o   = vld_r;
  assign ctl_o   = ctl_r;
  assign val_o   = val_r;
  assign exp_o   = exp_r;
  assign a_o     = a_r;
  assign b_o     = b_r;
  assign abs_a_o = abs_a_r;
  assign abs_b_o = abs_b_r;

endmodule

[rtl/core/caa_mul.sv]
// caa_mul: two-stage low-half multiplier built from three half-width partial products
// depends on nothing outside this file
module caa_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] prod
);
  localparam int LO = W / 2;
  localparam int HI = W - LO;

  logic [2*LO-1:0] p0_r;
  logic [HI-1:0]   p1_r, p2_r;
  logic [W-1:0]    prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
      p1_r   <= HI'(a[LO-1:0] * b[W-1:LO]);
      p2_r   <= HI'(a[W-1:LO] * b[LO-1:0]);
      // cross terms only reach the upper half of the result
      prod_r <= W'(p0_r) + {HI'(p1_r + p2_r), {LO{1'b0}}};
    end
  end

  assign prod = prod_r;

endmodule

[rtl/core/caa_div.sv]
// caa_div: pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on nothing outside this file
module caa_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  logic [W-1:0] rem_r [W];
  logic [W-1:0] q_r   [W];
  logic [W-1:0] d_r   [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0] rem_in, q_in, d_in;
    logic [W:0]   rem_sh, diff;
    logic         take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = dividend;
      assign d_in   = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign d_in   = d_r[i-1];
    end

    assign rem_sh = {rem_in, q_in[W-1]};
    assign diff   = rem_sh - {1'b0, d_in};
    assign take   = !diff[W];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? diff[W-1:0] : rem_sh[W-1:0];
        q_r[i]   <= {q_in[W-2:0], take};
        d_r[i]   <= d_in;
      end
    end
  end

  assign quot = q_r[W-1];
  assign rem  = rem_r[W-1];

endmodule

[rtl/core/checked_integer_alu.sv]
// checked_integer_alu: top level, stream ports, delay lines and the result stage
// depends on caa_pkg, caa_front, caa_mul, caa_div
//
// One request on the in_ channel carries an opcode, two operands with bound and
// integer tags, and an optional expected value. Each request yields exactly one
// result on the out_ channel: a status, a bind flag and the value, in order.
// Each request passes through one front stage, one divider stage per quotient bit,
// and the output register;
// every request takes the same path length so results stay in order.
// Throughput is one request per cycle while the receiver takes results.
// The whole pipeline advances together: when out_tvalid is high and out_tready is
// low, every stage holds and in_tready drops, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// There are no configuration registers and no kept state between requests.
module checked_integer_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[3:0], operand_a[67:4], operand_b[131:68], expected_value[195:132], zero pad
  input  logic [199:0] in_tdata,
  // a_bound[0], b_bound[1], a_is_integer[2], b_is_integer[3], expect_given[4]
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], bind_result[3], result_value[67:4], zero pad
  output logic [71:0]  out_tdata
);
  import caa_pkg::*;

  localparam int W = DATA_WIDTH;

  typedef struct packed {
    caa_ctl_t     ctl;
    logic [W-1:0] val;
    logic [W-1:0] expv;
  } pay_t;

  logic              en;
  logic              f_vld;
  caa_ctl_t          f_ctl;
  logic [W-1:0]      f_val, f_exp, f_a, f_b, f_abs_a, f_abs_b;
  logic [W-1:0]      mul_prod, div_q, div_r;
  logic              vld_r [W];
  pay_t              pay_r [W];
  logic [W-1:0]      md_r  [W-2];
  logic              out_tvalid_r;
  logic [71:0]       out_tdata_r, out_tdata_nxt;
  pay_t              p;
  logic signed [W-1:0] v;
  status_t           st;
  logic              bind_res;
  logic [63:0]       res64;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  caa_front #(.W(W)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .opcode         (in_tdata[3:0]),
    .operand_a      (in_tdata[67:4]),
    .operand_b      (in_tdata[131:68]),
    .a_bound        (in_tuser[0]),
    .b_bound        (in_tuser[1]),
    .a_is_integer   (in_tuser[2]),
    .b_is_integer   (in_tuser[3]),
    .expect_given   (in_tuser[4]),
    .expected_value (in_tdata[195:132]),
    .vld_o          (f_vld),
    .ctl_o          (f_ctl),
    .val_o          (f_val),
    .exp_o          (f_exp),
    .a_o            (f_a),
    .b_o            (f_b),
    .abs_a_o        (f_abs_a),
    .abs_b_o        (f_abs_b)
  );

  caa_mul #(.W(W)) u_mul (
    .clk  (clk),
    .en   (en),
    .a    (f_a),
    .b    (f_b),
    .prod (mul_prod)
  );

  caa_div #(.W(W)) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (f_abs_a),
    .divisor  (f_abs_b),
    .quot     (div_q),
    .rem      (div_r)
  );

  // control and front-stage results ride alongside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < W; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= f_vld;
      for (int i = 1; i < W; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
    if (en) begin
      pay_r[0] <= '{ctl: f_ctl, val: f_val, expv: f_exp};
      for (int i = 1; i < W; i++) begin
        pay_r[i] <= pay_r[i-1];
      end
      md_r[0] <= mul_prod;
      for (int i = 1; i < W - 2; i++) begin
        md_r[i] <= md_r[i-1];
      end
    end
  end

  assign p = pay_r[W-1];

  always_comb begin
    unique case (p.ctl.cls)
      CLS_VAL: v = p.val;
      CLS_MUL: v = md_r[W-3];
      CLS_DIV: v = p.ctl.neg_q ? -div_q : div_q;
      CLS_MOD: v = p.ctl.neg_r ? -div_r : div_r;
      default: v = '0;
    endcase
    st       = ST_OK;
    bind_res = 1'b0;
    res64    = '0;
    unique case (p.ctl.cls)
      CLS_ERR:  st = p.ctl.status;
      CLS_PRED: st = p.ctl.truth ? ST_OK : ST_FAIL;
      default: begin
        res64 = 64'(v);
        if (p.ctl.expect_given) begin
          st = (p.expv == v) ? ST_OK : ST_FAIL;
        end else begin
          bind_res = 1'b1;
        end
      end
    endcase
    out_tdata_nxt = {4'b0000, res64, bind_res, st};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_r[W-1];
    end
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[bench/tb_checked_integer_alu.sv]
// tb_checked_integer_alu: self-checking bench for the checked integer alu
// depends on caa_pkg and rtl/core/checked_integer_alu; predicts each result in the bench
module tb_checked_integer_alu;
  import caa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ev;
    logic [4:0]  tags;
  } alu_req_t;

  typedef struct {
    status_t     status;
    logic        bind_res;
    logic [63:0] value;
  } alu_res_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic [4:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       errors = 0;
  int       n_checked = 0;
  int       in_idle_pct = 33;
  int       out_idle_pct = 60;
  int       hold_cycles = 0;
  bit       feed_done = 0;

  checked_integer_alu #(.DATA_WIDTH(64)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic alu_res_t compute_alu(alu_req_t r);
    alu_res_t    res;
    logic        unary, pred, truth;
    logic [5:0]  amt;
    logic [63:0] v;
    res = '{ST_OK, 1'b0, 64'd0};
    unary = (r.op == OP_ABS) || (r.op == OP_NOT);
    pred = (r.op == OP_LT) || (r.op == OP_GE) || (r.op == OP_BIT);
    amt = r.b[5:0];
    v = '0;
    truth = 0;
    if (!r.tags[0] || (!unary && !r.tags[1])) begin
      res.status = ST_INSUF;
      return res;
    end
    if (!r.tags[2] || (!unary && !r.tags[3])) begin
      res.status = ST_INTNEED;
      return res;
    end
    if ((r.op == OP_DIV || r.op == OP_MOD) && r.b == 0) begin
      res.status = ST_DIVZERO;
      return res;
    end
    case (r.op)
      OP_ADD: v = r.a + r.b;
      OP_SUB: v = r.a - r.b;
      OP_MUL: v = r.a * r.b;
      OP_DIV: begin
        if (r.b == '1) v = -r.a;
        else v = $signed(r.a) / $signed(r.b);
      end
      OP_MOD: begin
        if (r.b == '1) v = '0;
        else v = $signed(r.a) % $signed(r.b);
      end
      OP_ABS: v = r.a[63] ? -r.a : r.a;
      OP_LT:  truth = $signed(r.a) < $signed(r.b);
      OP_GE:  truth = !($signed(r.a) < $signed(r.b));
      OP_AND: v = r.a & r.b;
      OP_OR:  v = r.a | r.b;
      OP_XOR: v = r.a ^ r.b;
      OP_SHL: v = r.a << amt;
      OP_LSR: v = r.a >> amt;
      OP_ASR: v = $signed(r.a) >>> amt;
      OP_NOT: v = ~r.a;
      default: truth = r.a[amt];
    endcase
    if (pred) begin
      res.status = truth ? ST_OK : ST_FAIL;
      return res;
    end
    if (r.tags[4]) res.status = (r.ev == v) ? ST_OK : ST_FAIL;
    else res.bind_res = 1;
    res.value = v;
    return res;
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return 64'd0;
      4: return 64'd1;
      5: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_req(op_t op, logic [63:0] a, logic [63:0] b, logic [63:0] ev,
                          logic [4:0] tags);
    alu_req_t r;
    r = '{op, a, b, ev, tags};
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(int n);
    logic [63:0] a, b, ev;
    logic [4:0]  tags;
    op_t         op;
    alu_res_t    p;
    repeat (n) begin
      op = op_t'($urandom_range(0, 15));
      a = edge_value();
      b = edge_value();
      tags = 5'b01111;
      if ($urandom_range(0, 9) == 0) tags[3:0] = 4'($urandom);
      tags[4] = 1'($urandom);
      ev = edge_value();
      // often check against the right value so the match path gets hit
      if (tags[4] && $urandom_range(0, 1)) begin
        p = compute_alu('{op, a, b, 64'd0, tags});
        ev = p.value;
      end
      push_req(op, a, b, ev, tags);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          alu_req_t r;
          r = pending_reqs.pop_front();
          expected_results.push_back(compute_alu(r));
          in_tdata <= {4'd0, r.ev, r.b, r.a, r.op};
          in_tuser <= r.tags;
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver readiness, with one long hold-off in the last phase
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alu_res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: %h", $time, out_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (out_tdata[2:0] !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[3] !== e.bind_res) begin
          $display("%0t: bind exp %0d got %0d", $time, e.bind_res, out_tdata[3]);
          errors++;
        end
        if (out_tdata[67:4] !== e.value) begin
          $display("%0t: value exp %h got %h", $time, e.value, out_tdata[67:4]);
          errors++;
        end
        if (out_tdata[71:68] !== 4'd0) begin
          $display("%0t: pad exp 0 got %h", $time, out_tdata[71:68]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: every opcode, extremes, tag errors, divide corners
    for (int i = 0; i < 16; i++)
      push_req(op_t'(i), 64'h8000_0000_0000_0000, '1, 64'd0, 5'b01111);
    push_req(OP_DIV, 64'd5, 64'd0, 0, 5'b01111);
    push_req(OP_MOD, 64'd5, 64'd0, 0, 5'b01111);
    push_req(OP_ADD, 1, 2, 0, 5'b01110);
    push_req(OP_ADD, 1, 2, 0, 5'b01101);
    push_req(OP_ABS, 1, 0, 0, 5'b00101);
    push_req(OP_SUB, 1, 2, 0, 5'b01011);
    push_req(OP_NOT, 1, 0, 0, 5'b00011);
    push_req(OP_ADD, 1, 2, 3, 5'b11111);
    push_req(OP_ASR, 64'h8000_0000_0000_0000, 64'd63, 0, 5'b01111);
    wait_drained();
    push_random(600);
    wait_drained();
    in_idle_pct = 60;
    out_idle_pct = 33;
    push_random(500);
    wait_drained();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 300;
    push_random(600);
    wait_drained();
    repeat (70) @(posedge clk);
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    $display("checked %0d results over all opcodes, tag errors and stall patterns",
             n_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule
